FILE: sv/tgbp_pkg.sv
// Package for the transition graph path search block.
// Holds the item and result types, function and status codes and the range check.
// No dependencies.
package tgbp_pkg;

	localparam int VARIABLES_DEF = 8;
	localparam int VALUES_DEF    = 16;

	// function codes of an input item
	localparam logic FUNC_ADD  = 1'b0;
	localparam logic FUNC_PATH = 1'b1;

	// status codes of a result item
	localparam logic [1:0] ST_STEP  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_NONE  = 2'd2;

	typedef struct packed {
		logic       func;
		logic [2:0] var_index;
		logic [3:0] from_value;
		logic [3:0] to_value;
	} item_t;

	typedef struct packed {
		logic [3:0] step_from;
		logic [3:0] step_to;
		logic [1:0] status;
		logic       last;
	} result_t;

	// adjacency store status seen by the top level
	typedef struct packed {
		logic clearing;
		logic add_busy;
	} graph_stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RESP,
		S_ADJ_RD,
		S_SCAN_LD,
		S_SCAN,
		S_Q_WAIT,
		S_WALK_WR,
		S_WALK_WAIT,
		S_EMIT_RD,
		S_EMIT_WAIT
	} srch_state_t;

	// true when variable and both values address an existing graph entry
	function automatic logic in_range(item_t it, int vars, int vals);
		return (int'(it.var_index) < vars) && (int'(it.from_value) < vals) &&
			(int'(it.to_value) < vals);
	endfunction

endpackage

FILE: sv/tgbp_graph.sv
// Adjacency row store: one row of edge bits per variable and source value.
// Clears itself after reset and runs edge adds as read-modify-write.
// Depends on tgbp_pkg.
module tgbp_graph #(
	parameter int VARIABLES = tgbp_pkg::VARIABLES_DEF,
	parameter int VALUES    = tgbp_pkg::VALUES_DEF,
	localparam int ROWS     = VARIABLES * VALUES,
	localparam int AW       = $clog2(ROWS),
	localparam int VW       = $clog2(VALUES)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  add_en,
	input  logic [AW-1:0]         add_addr,
	input  logic [VW-1:0]         add_col,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output logic [VALUES-1:0]     rd_data,
	output tgbp_pkg::graph_stat_t stat
);
	import tgbp_pkg::*;

	logic [VALUES-1:0] mem_q [ROWS];
	logic [VALUES-1:0] rd_data_q;
	logic              clr_busy_q;
	logic [AW-1:0]     clr_addr_q;
	logic              add_pend_s1;
	logic [AW-1:0]     add_addr_s1;
	logic [VW-1:0]     add_col_s1;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [VALUES-1:0] wdata;
	logic              re;
	logic [AW-1:0]     raddr;

	// select write: clearing sweep first, then the write half of an add
	always_comb begin
		we    = 1'b0;
		waddr = clr_addr_q;
		wdata = '0;
		priority if (clr_busy_q) begin
			we = 1'b1;
		end else if (add_pend_s1) begin
			we    = 1'b1;
			waddr = add_addr_s1;
			wdata = rd_data_q | (VALUES'(1) << add_col_s1);
		end
	end

	// share the read port between add and search
	assign re    = add_en || rd_en;
	assign raddr = add_en ? add_addr : rd_addr;

	// memory array, registered read data held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rd_data_q <= mem_q[raddr];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// clearing sweep and add sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
			add_pend_s1 <= 1'b0;
		end else begin
			add_pend_s1 <= add_en;
			if (clr_busy_q) begin
				if (clr_addr_q == AW'(ROWS - 1)) begin
					clr_busy_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + AW'(1);
				end
			end
		end
	end

	// hold the add target for the write half
	always_ff @(posedge clk) begin
		if (add_en) begin
			add_addr_s1 <= add_addr;
			add_col_s1  <= add_col;
		end
	end

	assign rd_data        = rd_data_q;
	assign stat.clearing  = clr_busy_q;
	assign stat.add_busy  = add_pend_s1;

`ifndef ASSERT_OFF
	a_no_access_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !add_en && !rd_en)
		else $error("graph accessed during clearing sweep");
	a_single_reader: assert property (@(posedge clk) disable iff (!arst_n)
		!(add_en && rd_en))
		else $error("add and search read the row store together");
	a_no_add_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		add_pend_s1 |-> !add_en && !rd_en)
		else $error("access overlaps the write half of an add");
`endif

endmodule

FILE: sv/tgbp_search.sv
// Breadth-first search sequencer with its queue memory.
// Queue entries keep node and parent slot; the upper half holds the path for output.
// Depends on tgbp_pkg; reads rows from tgbp_graph.
module tgbp_search #(
	parameter int VARIABLES = tgbp_pkg::VARIABLES_DEF,
	parameter int VALUES    = tgbp_pkg::VALUES_DEF,
	localparam int ROWS     = VARIABLES * VALUES,
	localparam int AW       = $clog2(ROWS),
	localparam int VW       = $clog2(VALUES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  tgbp_pkg::item_t   item,
	output logic              idle,
	output logic              adj_rd,
	output logic [AW-1:0]     adj_addr,
	input  logic [VALUES-1:0] adj_data,
	input  logic              slot_free,
	output logic              push,
	output tgbp_pkg::result_t push_data
);
	import tgbp_pkg::*;

	localparam int QAW   = VW + 1;
	localparam int QD    = 2 ** QAW;
	localparam int EW    = 2 * VW;

	// queue memory
	logic [EW-1:0]  qmem_q [QD];
	logic [EW-1:0]  q_rdata_q;
	logic           q_we;
	logic [QAW-1:0] q_waddr;
	logic [EW-1:0]  q_wdata;
	logic           q_re;
	logic [QAW-1:0] q_raddr;
	logic [VW-1:0]  q_node;
	logic [VW-1:0]  q_par;

	srch_state_t       state_q, state_d;
	logic [2:0]        var_q, var_d;
	logic [VW-1:0]     src_q, src_d;
	logic [VW-1:0]     dst_q, dst_d;
	logic [VW-1:0]     cur_q, cur_d;
	logic [VW-1:0]     cur_idx_q, cur_idx_d;
	logic [VW-1:0]     cur_par_q, cur_par_d;
	logic [VW:0]       head_q, head_d;
	logic [VW:0]       tail_q, tail_d;
	logic [VALUES-1:0] visited_q, visited_d;
	logic [VALUES-1:0] cand_q, cand_d;
	logic [1:0]        resp_q, resp_d;
	logic [VW-1:0]     walk_node_q, walk_node_d;
	logic [VW-1:0]     walk_par_q, walk_par_d;
	logic [VW-1:0]     walk_idx_q, walk_idx_d;
	logic [VW-1:0]     j_q, j_d;
	logic [VW-1:0]     prev_q, prev_d;
	logic [VALUES-1:0] pick_bit;
	logic [VW-1:0]     pick;

	assign q_node = q_rdata_q[EW-1:VW];
	assign q_par  = q_rdata_q[VW-1:0];

	// isolate the lowest candidate and encode its value
	always_comb begin
		pick_bit = cand_q & (~cand_q + VALUES'(1));
		pick     = '0;
		for (int i = 0; i < VALUES; i++) begin
			if (pick_bit[i]) begin
				pick = pick | VW'(i);
			end
		end
	end

	// next state and outputs
	always_comb begin
		state_d     = state_q;
		var_d       = var_q;
		src_d       = src_q;
		dst_d       = dst_q;
		cur_d       = cur_q;
		cur_idx_d   = cur_idx_q;
		cur_par_d   = cur_par_q;
		head_d      = head_q;
		tail_d      = tail_q;
		visited_d   = visited_q;
		cand_d      = cand_q;
		resp_d      = resp_q;
		walk_node_d = walk_node_q;
		walk_par_d  = walk_par_q;
		walk_idx_d  = walk_idx_q;
		j_d         = j_q;
		prev_d      = prev_q;
		q_we        = 1'b0;
		q_waddr     = '0;
		q_wdata     = '0;
		q_re        = 1'b0;
		q_raddr     = '0;
		adj_rd      = 1'b0;
		adj_addr    = AW'(int'(var_q) * VALUES + int'(cur_q));
		push        = 1'b0;
		push_data   = '0;
		idle        = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				idle = 1'b1;
				if (start) begin
					priority if (item.from_value == item.to_value) begin
						resp_d  = ST_EMPTY;
						state_d = S_RESP;
					end else if (!in_range(item, VARIABLES, VALUES)) begin
						resp_d  = ST_NONE;
						state_d = S_RESP;
					end else begin
						var_d     = item.var_index;
						src_d     = VW'(item.from_value);
						dst_d     = VW'(item.to_value);
						cur_d     = VW'(item.from_value);
						cur_idx_d = '0;
						cur_par_d = '0;
						head_d    = (VW+1)'(1);
						tail_d    = (VW+1)'(1);
						visited_d = VALUES'(1) << VW'(item.from_value);
						q_we      = 1'b1;
						q_waddr   = '0;
						q_wdata   = {VW'(item.from_value), VW'(0)};
						state_d   = S_ADJ_RD;
					end
				end
			end
			S_RESP: begin
				if (slot_free) begin
					push             = 1'b1;
					push_data.status = resp_q;
					push_data.last   = 1'b1;
					state_d          = S_IDLE;
				end
			end
			S_ADJ_RD: begin
				adj_rd  = 1'b1;
				state_d = S_SCAN_LD;
			end
			S_SCAN_LD: begin
				// drop visited values and the self edge
				cand_d  = adj_data & ~visited_q & ~(VALUES'(1) << cur_q);
				state_d = S_SCAN;
			end
			S_SCAN: begin
				if (cand_q == '0) begin
					if (head_q < tail_q) begin
						q_re      = 1'b1;
						q_raddr   = {1'b0, head_q[VW-1:0]};
						cur_idx_d = head_q[VW-1:0];
						head_d    = head_q + (VW+1)'(1);
						state_d   = S_Q_WAIT;
					end else begin
						resp_d  = ST_NONE;
						state_d = S_RESP;
					end
				end else begin
					visited_d = visited_q | pick_bit;
					cand_d    = cand_q & ~pick_bit;
					if (pick == dst_q) begin
						// destination reached: path slot zero holds it
						q_we        = 1'b1;
						q_waddr     = {1'b1, VW'(0)};
						q_wdata     = {dst_q, VW'(0)};
						walk_node_d = cur_q;
						walk_par_d  = cur_par_q;
						walk_idx_d  = cur_idx_q;
						j_d         = VW'(1);
						state_d     = S_WALK_WR;
					end else begin
						q_we    = 1'b1;
						q_waddr = {1'b0, tail_q[VW-1:0]};
						q_wdata = {pick, cur_idx_q};
						tail_d  = tail_q + (VW+1)'(1);
					end
				end
			end
			S_Q_WAIT: begin
				cur_d     = q_node;
				cur_par_d = q_par;
				state_d   = S_ADJ_RD;
			end
			S_WALK_WR: begin
				q_we    = 1'b1;
				q_waddr = {1'b1, j_q};
				q_wdata = {walk_node_q, VW'(0)};
				if (walk_idx_q == '0) begin
					// source reached: emit from the slot below it
					prev_d  = src_q;
					j_d     = j_q - VW'(1);
					state_d = S_EMIT_RD;
				end else begin
					q_re       = 1'b1;
					q_raddr    = {1'b0, walk_par_q};
					walk_idx_d = walk_par_q;
					j_d        = j_q + VW'(1);
					state_d    = S_WALK_WAIT;
				end
			end
			S_WALK_WAIT: begin
				walk_node_d = q_node;
				walk_par_d  = q_par;
				state_d     = S_WALK_WR;
			end
			S_EMIT_RD: begin
				q_re    = 1'b1;
				q_raddr = {1'b1, j_q};
				state_d = S_EMIT_WAIT;
			end
			S_EMIT_WAIT: begin
				if (slot_free) begin
					push                = 1'b1;
					push_data.step_from = 4'(prev_q);
					push_data.step_to   = 4'(q_node);
					push_data.status    = ST_STEP;
					push_data.last      = (j_q == '0);
					prev_d              = q_node;
					if (j_q == '0) begin
						state_d = S_IDLE;
					end else begin
						j_d     = j_q - VW'(1);
						state_d = S_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// queue memory, read data held between reads
	always_ff @(posedge clk) begin
		if (q_re) begin
			q_rdata_q <= qmem_q[q_raddr];
		end
		if (q_we) begin
			qmem_q[q_waddr] <= q_wdata;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			tail_q    <= '0;
			visited_q <= '0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			visited_q <= visited_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		var_q       <= var_d;
		src_q       <= src_d;
		dst_q       <= dst_d;
		cur_q       <= cur_d;
		cur_idx_q   <= cur_idx_d;
		cur_par_q   <= cur_par_d;
		cand_q      <= cand_d;
		resp_q      <= resp_d;
		walk_node_q <= walk_node_d;
		walk_par_q  <= walk_par_d;
		walk_idx_q  <= walk_idx_d;
		j_q         <= j_d;
		prev_q      <= prev_d;
	end

`ifndef ASSERT_OFF
	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(tail_q) <= VALUES)
		else $error("search queue overflow");
	a_head_le_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("queue head passed tail");
	a_push_slot: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> slot_free)
		else $error("result pushed into a full output slot");
	a_walk_write_high: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK_WR) |-> q_we && q_waddr[VW])
		else $error("path write outside the path half");
`endif

endmodule

FILE: sv/transition_graph_bfs_path.sv
// In-range add: row read on accept, row write in the next cycle; next item taken after that.
// Path item: equal or out-of-range endpoints answer from the response state. A search reads
// the queue and then the row store for each dequeued value and scans its newly found
// neighbors one by one, then walks back to write the path and emits its steps (queue memory).
// Reset: a sweep clears all VARIABLES*VALUES rows while item_ready is low.
module transition_graph_bfs_path #(
	parameter int VARIABLES = tgbp_pkg::VARIABLES_DEF,
	parameter int VALUES    = tgbp_pkg::VALUES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  tgbp_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output tgbp_pkg::result_t result
);
	import tgbp_pkg::*;

	localparam int ROWS = VARIABLES * VALUES;
	localparam int AW   = $clog2(ROWS);
	localparam int VW   = $clog2(VALUES);

	graph_stat_t       gstat;
	logic              srch_idle;
	logic              acc;
	logic              add_en;
	logic [AW-1:0]     add_addr;
	logic [VW-1:0]     add_col;
	logic              srch_start;
	logic              adj_rd;
	logic [AW-1:0]     adj_addr;
	logic [VALUES-1:0] adj_data;
	logic              slot_free;
	logic              push;
	result_t           push_data;
	logic              result_valid_q;
	result_t           result_q;

	// accept while the row store is quiet and the search is idle
	assign item_ready = !gstat.clearing && !gstat.add_busy && srch_idle;
	assign acc        = item_valid && item_ready;

	// route items: in-range adds to the row store, queries to the search
	assign add_en     = acc && (item.func == FUNC_ADD) && in_range(item, VARIABLES, VALUES);
	assign add_addr   = AW'(int'(item.var_index) * VALUES + int'(item.from_value));
	assign add_col    = VW'(item.to_value);
	assign srch_start = acc && (item.func == FUNC_PATH);

	tgbp_graph #(
		.VARIABLES (VARIABLES),
		.VALUES    (VALUES)
	) u_graph (
		.clk      (clk),
		.arst_n   (arst_n),
		.add_en   (add_en),
		.add_addr (add_addr),
		.add_col  (add_col),
		.rd_en    (adj_rd),
		.rd_addr  (adj_addr),
		.rd_data  (adj_data),
		.stat     (gstat)
	);

	tgbp_search #(
		.VARIABLES (VARIABLES),
		.VALUES    (VALUES)
	) u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (srch_start),
		.item      (item),
		.idle      (srch_idle),
		.adj_rd    (adj_rd),
		.adj_addr  (adj_addr),
		.adj_data  (adj_data),
		.slot_free (slot_free),
		.push      (push),
		.push_data (push_data)
	);

	// output register: load on push, drop when taken
	assign slot_free = !result_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (push) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			result_q <= push_data;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !item_ready)
		else $error("item accepted while previous item still in progress");
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");
	a_add_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		add_en |=> !push)
		else $error("add item produced a result");
`endif

endmodule

FILE: sim/transition_graph_bfs_path_tb.sv
`timescale 1ns / 100ps
// Testbench for transition_graph_bfs_path: edge adds and shortest path queries under
// random stalls on both channels. Depends on tgbp_pkg and the block's top level only.
module transition_graph_bfs_path_tb;
	import tgbp_pkg::*;

	localparam int LIMIT_CYCLES = 1_500_000;
	localparam int DRAIN_CYCLES = 250;
	localparam int RANDOM_ITEMS = 346;

	// Shadow graph store and the queue of path steps still owed by the block
	class path_scoreboard;
		logic [15:0] graph_rows [VARIABLES_DEF][VALUES_DEF];
		result_t     owed_steps [$];
		int          errors;
		int          n_adds, n_queries, n_steps, n_empty, n_none;

		function new();
			foreach (graph_rows[i, j]) graph_rows[i][j] = '0;
			errors = 0;
			n_adds = 0;
			n_queries = 0;
			n_steps = 0;
			n_empty = 0;
			n_none = 0;
		endfunction

		// Update the shadow graph, or run the search and queue the steps it yields
		function void note_item(item_t it);
			logic [15:0] seen;
			logic [15:0] row;
			logic [3:0]  fifo [VALUES_DEF];
			logic [3:0]  came_from [VALUES_DEF];
			logic [3:0]  trail [VALUES_DEF];
			logic [3:0]  cur;
			logic [3:0]  v;
			int          head, tail, n;
			bit          found;
			result_t     r;

			if (it.func == FUNC_ADD) begin
				n_adds++;
				if (int'(it.var_index) < VARIABLES_DEF && int'(it.from_value) < VALUES_DEF &&
						int'(it.to_value) < VALUES_DEF)
					graph_rows[it.var_index][it.from_value][it.to_value] = 1'b1;
				return;
			end
			n_queries++;

			// equal endpoints are answered before any range check
			if (it.from_value == it.to_value) begin
				r = '{step_from: 4'd0, step_to: 4'd0, status: ST_EMPTY, last: 1'b1};
				owed_steps.push_back(r);
				n_empty++;
				return;
			end
			found = 1'b0;
			if (int'(it.var_index) < VARIABLES_DEF && int'(it.from_value) < VALUES_DEF &&
					int'(it.to_value) < VALUES_DEF) begin
				// breadth-first, neighbors in ascending order, self edges skipped
				seen = '0;
				seen[it.from_value] = 1'b1;
				came_from[it.from_value] = it.from_value;
				head = 0;
				tail = 0;
				fifo[tail] = it.from_value;
				tail++;
				while (head < tail && !found) begin
					cur = fifo[head];
					head++;
					row = graph_rows[it.var_index][cur];
					for (int i = 0; i < VALUES_DEF; i++) begin
						if (i == int'(cur) || seen[i] || !row[i])
							continue;
						seen[i] = 1'b1;
						came_from[i] = cur;
						if (i == int'(it.to_value)) begin
							found = 1'b1;
							break;
						end
						if (tail < VALUES_DEF) begin
							fifo[tail] = 4'(i);
							tail++;
						end
					end
				end
			end
			if (!found) begin
				r = '{step_from: 4'd0, step_to: 4'd0, status: ST_NONE, last: 1'b1};
				owed_steps.push_back(r);
				n_none++;
				return;
			end

			// walk back from the destination, then queue the steps source first
			n = 0;
			v = it.to_value;
			trail[n] = v;
			n++;
			while (v != it.from_value && n < VALUES_DEF) begin
				v = came_from[v];
				trail[n] = v;
				n++;
			end
			for (int i = 0; i + 1 < n; i++) begin
				r.step_from = trail[n - 1 - i];
				r.step_to   = trail[n - 2 - i];
				r.status    = ST_STEP;
				r.last      = (i + 2 == n);
				owed_steps.push_back(r);
				n_steps++;
			end
		endfunction

		// Compare one accepted result with the oldest owed one
		function void check_result(result_t got);
			result_t exp;

			if (owed_steps.size() == 0) begin
				$display("%0t: result with nothing owed: from=%0d to=%0d status=%0d last=%0d",
					$time, got.step_from, got.step_to, got.status, got.last);
				errors++;
				return;
			end
			exp = owed_steps.pop_front();
			if (got.step_from !== exp.step_from) begin
				$display("%0t: step_from expected %0d actual %0d", $time, exp.step_from,
					got.step_from);
				errors++;
			end
			if (got.step_to !== exp.step_to) begin
				$display("%0t: step_to expected %0d actual %0d", $time, exp.step_to,
					got.step_to);
				errors++;
			end
			if (got.status !== exp.status) begin
				$display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
				errors++;
			end
			if (got.last !== exp.last) begin
				$display("%0t: last expected %0d actual %0d", $time, exp.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	path_scoreboard sb;
	int             cycles;

	transition_graph_bfs_path DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		result_ready = 1'b0;
		cycles       = 0;
		sb           = new();
	end

	always #5 clk = ~clk;

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d results still owed", $time, sb.owed_steps.size());
			$display("[transition_graph_bfs_path] ERROR");
			$finish;
		end
	end

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 85)
			return $urandom_range(1, 3);
		if (p < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Favor the end values now and then
	function automatic logic [3:0] pick_value();
		int p;
		p = $urandom_range(0, 99);
		if (p < 12)
			return 4'd0;
		if (p < 24)
			return 4'd15;
		return 4'($urandom_range(0, 15));
	endfunction

	function automatic item_t mk_item(logic f, int vi, int fv, int tv);
		item_t it;
		it.func       = f;
		it.var_index  = 3'(vi);
		it.from_value = 4'(fv);
		it.to_value   = 4'(tv);
		return it;
	endfunction

	// Hold the item until accepted, then idle for a while unless calm
	task automatic send_item(item_t it, bit calm);
		int gap;
		item       <= it;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (item_ready !== 1'b1);
		sb.note_item(it);
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Take results, stalling at random with calm windows
	initial begin
		int stall;
		bit calm;
		stall = 0;
		forever begin
			@(posedge clk);
			if (result_valid === 1'b1 && result_ready === 1'b1)
				sb.check_result(result);
			calm = ((cycles / 3000) % 4) == 3;
			if (stall > 0) begin
				result_ready <= 1'b0;
				stall--;
			end else begin
				result_ready <= 1'b1;
				if (!calm && $urandom_range(0, 3) == 0)
					stall = pick_gap();
			end
		end
	end

	// Stimulus and final report
	initial begin
		item_t directed [$];
		item_t it;
		int    p;
		bit    calm;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// longest path: chain 0 -> 1 -> ... -> 15 in graph 0
		for (int i = 0; i < 15; i++)
			directed.push_back(mk_item(FUNC_ADD, 0, i, i + 1));
		directed.push_back(mk_item(FUNC_PATH, 0, 0, 15));
		// unreachable destination, equal endpoints, empty graph
		directed.push_back(mk_item(FUNC_PATH, 0, 15, 0));
		directed.push_back(mk_item(FUNC_PATH, 0, 6, 6));
		directed.push_back(mk_item(FUNC_PATH, 5, 0, 15));
		// self edge stored but never followed, then a repeated add
		directed.push_back(mk_item(FUNC_ADD, 2, 3, 3));
		directed.push_back(mk_item(FUNC_ADD, 2, 3, 3));
		directed.push_back(mk_item(FUNC_PATH, 2, 3, 9));
		directed.push_back(mk_item(FUNC_ADD, 2, 3, 9));
		directed.push_back(mk_item(FUNC_PATH, 2, 3, 9));
		directed.push_back(mk_item(FUNC_PATH, 7, 15, 0));
		foreach (directed[i])
			send_item(directed[i], 1'b0);

		// random mix: adds grow the graphs, queries search them
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = ((n / 50) % 3) == 1;
			it.var_index  = 3'($urandom_range(0, 7));
			it.from_value = pick_value();
			p = $urandom_range(0, 99);
			if (p < 58) begin
				it.func = FUNC_ADD;
				// neighbor edges now and then stretch the paths
				if (p < 18)
					it.to_value = it.from_value + 4'd1;
				else
					it.to_value = pick_value();
			end else begin
				it.func     = FUNC_PATH;
				it.to_value = (p < 63) ? it.from_value : pick_value();
			end
			send_item(it, calm);
		end
		item_valid <= 1'b0;

		// wait for every owed result, then watch for strays
		while (sb.owed_steps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d edge adds and %0d path queries in %0d cycles.",
			sb.n_adds, sb.n_queries, cycles);
		$display("Predicted %0d path steps, %0d empty answers, %0d no-path answers.",
			sb.n_steps, sb.n_empty, sb.n_none);
		if (sb.errors == 0) begin
			$display("[transition_graph_bfs_path] OK");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("[transition_graph_bfs_path] ERROR");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/tgbp_pkg.sv
sv/tgbp_graph.sv
sv/tgbp_search.sv
sv/transition_graph_bfs_path.sv
sim/transition_graph_bfs_path_tb.sv
